### src/rpur_pkg.sv
// Shared types and constants for the raw pixel unpack and rescale block.
package rpur_pkg;

  localparam int SampleW = 17;
  localparam int CoefW   = 32;
  localparam int ProdW   = SampleW + CoefW;
  localparam int SumW    = ProdW + 1;
  localparam int FracW   = 16;
  localparam int PixelW  = 32;
  localparam int CfgIdxW = 3;

  localparam logic [CoefW-1:0] SlopeUnit = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_8  = 2'd0,
    MODE_12 = 2'd1,
    MODE_16 = 2'd2
  } sample_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_MODE       = 3'd0,
    REG_SWAP_BYTES        = 3'd1,
    REG_SIGNED_SAMPLES    = 3'd2,
    REG_RESCALE_SLOPE     = 3'd3,
    REG_RESCALE_INTERCEPT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] sample_mode;
    logic       swap_bytes;
    logic       signed_samples;
  } unpack_cfg_t;

endpackage

### src/rpur_unpack.sv
// Byte grouping and sample assembly with a registered sample output.
module rpur_unpack (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rpur_pkg::unpack_cfg_t                cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  input  logic                                 first_byte,
  output logic                                 sample_valid,
  input  logic                                 sample_ready,
  output logic signed [rpur_pkg::SampleW-1:0]  sample_value
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  phase_t     phase, phase_next, phase_eff;
  logic [7:0] held_a, held_b;
  logic       load_a, load_b, emit;
  logic [7:0] word_first, word_second;
  logic       wide;
  logic [15:0] word;
  logic signed [rpur_pkg::SampleW-1:0] value_next;
  logic       accept;

  assign in_ready = !sample_valid || sample_ready;
  assign accept   = in_valid && in_ready;
  assign phase_eff = first_byte ? PH_FIRST : phase;

  always_comb begin
    phase_next  = PH_FIRST;
    load_a      = 1'b0;
    load_b      = 1'b0;
    emit        = 1'b1;
    wide        = 1'b1;
    word_first  = held_a;
    word_second = data_byte;
    unique case (cfg.sample_mode)
      rpur_pkg::MODE_16: begin
        if (phase_eff == PH_FIRST) begin
          load_a     = 1'b1;
          emit       = 1'b0;
          phase_next = PH_SECOND;
        end
      end
      rpur_pkg::MODE_12: begin
        if (phase_eff == PH_FIRST) begin
          load_a     = 1'b1;
          emit       = 1'b0;
          phase_next = PH_SECOND;
        end else if (phase_eff == PH_SECOND) begin
          load_b      = 1'b1;
          phase_next  = PH_THIRD;
          word_second = {4'h0, data_byte[3:0]};
        end else begin
          word_first  = {data_byte[3:0], held_b[7:4]};
          word_second = {4'h0, data_byte[7:4]};
        end
      end
      default: begin
        wide = 1'b0;
      end
    endcase
  end

  assign word = cfg.swap_bytes ? {word_first, word_second} : {word_second, word_first};

  always_comb begin
    if (wide) begin
      value_next = {cfg.signed_samples && word[15], word};
    end else begin
      value_next = {{9{cfg.signed_samples && data_byte[7]}}, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      held_a       <= '0;
      held_b       <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        if (load_a) begin
          held_a <= data_byte;
        end
        if (load_b) begin
          held_b <= data_byte;
        end
      end
      if (in_ready) begin
        sample_valid <= in_valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      sample_value <= value_next;
    end
  end

  a_mode8_no_group: assert property (@(posedge clk) disable iff (rst)
    accept && (cfg.sample_mode == rpur_pkg::MODE_8) |=> phase == PH_FIRST)
    else $error("8-bit byte left a group open");

  a_first16_holds: assert property (@(posedge clk) disable iff (rst)
    accept && first_byte && (cfg.sample_mode == rpur_pkg::MODE_16) |=> !sample_valid)
    else $error("first byte of a 16-bit pair gave a sample");

  a_pair_closes: assert property (@(posedge clk) disable iff (rst)
    accept && !first_byte && (phase == PH_SECOND) &&
    (cfg.sample_mode == rpur_pkg::MODE_16) |=> sample_valid && phase == PH_FIRST)
    else $error("second byte of a 16-bit pair gave no sample");

endmodule

### src/rpur_rescale.sv
// Q16.16 rescale pipeline: multiply, add intercept, truncate and saturate; a unit slope passes the sample through.
module rpur_rescale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [rpur_pkg::CoefW-1:0]    slope,
  input  logic signed [rpur_pkg::CoefW-1:0]    intercept,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rpur_pkg::SampleW-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rpur_pkg::PixelW-1:0]          pixel_value,
  output logic                                 saturated
);

  localparam int QW = rpur_pkg::SumW - rpur_pkg::FracW;

  logic                                 p_valid, s_valid;
  logic                                 p_ready, s_ready, o_ready;
  logic                                 p_unit, s_unit;
  logic signed [rpur_pkg::SampleW-1:0]  p_value, s_value;
  logic signed [rpur_pkg::ProdW-1:0]    prod_next, prod;
  logic signed [rpur_pkg::SumW-1:0]     sum_next, sum;
  logic signed [QW-1:0]                 quot;
  logic                                 round_up, sat_hi, sat_lo;
  logic [rpur_pkg::PixelW-1:0]          pixel_next;
  logic                                 sat_next;

  assign o_ready  = !out_valid || out_ready;
  assign s_ready  = !s_valid || o_ready;
  assign p_ready  = !p_valid || s_ready;
  assign in_ready = p_ready;

  assign prod_next = in_value * slope;
  assign sum_next  = rpur_pkg::SumW'(prod) + rpur_pkg::SumW'(intercept);

  // truncate toward zero: negative values with a fraction step up by one
  assign round_up = sum[rpur_pkg::SumW-1] && (|sum[rpur_pkg::FracW-1:0]);
  assign quot     = sum[rpur_pkg::SumW-1:rpur_pkg::FracW] + QW'(round_up);
  assign sat_hi   = !quot[QW-1] && (|quot[QW-2:rpur_pkg::PixelW-1]);
  assign sat_lo   = quot[QW-1] && !(&quot[QW-2:rpur_pkg::PixelW-1]);

  always_comb begin
    sat_next = 1'b0;
    if (s_unit) begin
      pixel_next = rpur_pkg::PixelW'(s_value);
    end else if (sat_hi) begin
      pixel_next = {1'b0, {(rpur_pkg::PixelW-1){1'b1}}};
      sat_next   = 1'b1;
    end else if (sat_lo) begin
      pixel_next = {1'b1, {(rpur_pkg::PixelW-1){1'b0}}};
      sat_next   = 1'b1;
    end else begin
      pixel_next = quot[rpur_pkg::PixelW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (s_ready) begin
        s_valid <= p_valid;
      end
      if (o_ready) begin
        out_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && p_ready) begin
      prod    <= prod_next;
      p_value <= in_value;
      p_unit  <= (slope == rpur_pkg::SlopeUnit);
    end
    if (p_valid && s_ready) begin
      sum     <= sum_next;
      s_value <= p_value;
      s_unit  <= p_unit;
    end
    if (s_valid && o_ready) begin
      pixel_value <= pixel_next;
      saturated   <= sat_next;
    end
  end

endmodule

### src/raw_pixel_unpack_rescale_top.sv
// Top level of the raw pixel unpack and rescale block with its register file.
// Takes one raw pixel byte per beat and returns integer pixels: one per byte
// in 8-bit mode, one per byte pair in 16-bit mode, two per three bytes in
// 12-bit packed mode. A byte is accepted every cycle while the output drains;
// the path from input to output is four register stages (sample register,
// product register, sum register, output register). The single 17x32 multiply
// sets the depth. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no beat is in flight, as the block
// itself does not enforce it; unknown indexes are ignored.
module raw_pixel_unpack_rescale_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rpur_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [rpur_pkg::CoefW-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] first_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rpur_pkg::PixelW-1:0]       m_tdata,   // [31:0] pixel_value
  output logic                              m_tuser    // [0] saturated
);

  rpur_pkg::unpack_cfg_t                cfg;
  logic signed [rpur_pkg::CoefW-1:0]    slope, intercept;
  logic                                 smp_valid, smp_ready;
  logic signed [rpur_pkg::SampleW-1:0]  smp_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_mode    <= rpur_pkg::MODE_8;
      cfg.swap_bytes     <= 1'b0;
      cfg.signed_samples <= 1'b0;
      slope              <= rpur_pkg::SlopeUnit;
      intercept          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpur_pkg::REG_SAMPLE_MODE:       cfg.sample_mode    <= cfg_data[1:0];
        rpur_pkg::REG_SWAP_BYTES:        cfg.swap_bytes     <= cfg_data[0];
        rpur_pkg::REG_SIGNED_SAMPLES:    cfg.signed_samples <= cfg_data[0];
        rpur_pkg::REG_RESCALE_SLOPE:     slope              <= cfg_data;
        rpur_pkg::REG_RESCALE_INTERCEPT: intercept          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpur_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .data_byte    (s_tdata),
    .first_byte   (s_tuser),
    .sample_valid (smp_valid),
    .sample_ready (smp_ready),
    .sample_value (smp_value)
  );

  rpur_rescale u_rescale (
    .clk         (clk),
    .rst         (rst),
    .slope       (slope),
    .intercept   (intercept),
    .in_valid    (smp_valid),
    .in_ready    (smp_ready),
    .in_value    (smp_value),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_value (m_tdata),
    .saturated   (m_tuser)
  );

  a_sat_needs_rescale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> slope != rpur_pkg::SlopeUnit)
    else $error("saturation flagged with unit slope");

  a_unit_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (slope == rpur_pkg::SlopeUnit) |->
    (m_tdata[31:16] == 16'h0000) || (m_tdata[31:16] == 16'hFFFF))
    else $error("unscaled pixel outside sample range");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output beat right after reset");

endmodule
